@@ sv/mrupr_pkg.sv @@
// Package for the MRU page replacement block.
// Holds the sequencer state type and the fixed hit counter width.
// No dependencies.
package mrupr_pkg;

	localparam int HIT_W = 16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ST_RD,
		S_ST_CMP,
		S_ROT_RD,
		S_ROT_WR,
		S_EV_RD,
		S_EV_CAP,
		S_TOP_WR,
		S_FILL,
		S_FR_RD,
		S_FR_CMP,
		S_DONE
	} mrupr_state_t;

endpackage

@@ sv/mrupr_ram.sv @@
// Small single-write, single-read RAM with a registered read port.
// Used for the frame table and the recency stack. No dependencies.
module mrupr_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/mru_page_replacement.sv @@
// MRU page replacement: recency stack and frame table in two small RAMs, scanned by a single
// shared comparator; each entry takes a RAM read, then a compare or write. A new transaction
// is not accepted until the current one is done: in_stall stays high until the result is
// loaded into the output register. Reset clears sequencer, counts and output valid only.
module mru_page_replacement #(
	parameter int FRAME_COUNT  = 8,
	parameter int PAGE_ID_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [PAGE_ID_BITS-1:0]        page_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [$clog2(FRAME_COUNT)-1:0] frame_index,
	output logic                           evicted,
	output logic [PAGE_ID_BITS-1:0]        evicted_page,
	output logic [mrupr_pkg::HIT_W-1:0]    hit_total
);

	import mrupr_pkg::*;

	localparam int IW  = $clog2(FRAME_COUNT);
	localparam int CW  = $clog2(FRAME_COUNT + 1);
	localparam int CW1 = CW + 1;

	mrupr_state_t state_q, state_d;

	logic [CW-1:0]           filled_q;
	logic [HIT_W-1:0]        hit_cnt_q;
	logic                    out_valid_q;
	logic [IW-1:0]           idx_q;
	logic [PAGE_ID_BITS-1:0] page_q;
	logic [PAGE_ID_BITS-1:0] key_q;
	logic                    hit_q;
	logic                    evict_q;
	logic [PAGE_ID_BITS-1:0] ev_page_q;
	logic [IW-1:0]           frame_q;

	logic                    out_hit_q;
	logic [IW-1:0]           out_frame_q;
	logic                    out_evict_q;
	logic [PAGE_ID_BITS-1:0] out_ev_page_q;
	logic [HIT_W-1:0]        out_hit_total_q;

	logic                    stk_we, frm_we;
	logic [IW-1:0]           stk_waddr, stk_raddr, frm_waddr, frm_raddr;
	logic [PAGE_ID_BITS-1:0] stk_wdata, frm_wdata, stk_rdata, frm_rdata;

	logic                    accept;
	logic                    load_out;
	logic [PAGE_ID_BITS-1:0] cmp_a;
	logic                    match;
	logic [CW1-1:0]          idx_ext;
	logic                    more;
	logic                    rot_more;
	logic                    full;
	logic [CW-1:0]           top_cnt;

	mrupr_ram #(.DEPTH(FRAME_COUNT), .WIDTH(PAGE_ID_BITS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	mrupr_ram #(.DEPTH(FRAME_COUNT), .WIDTH(PAGE_ID_BITS)) u_frames (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_waddr),
		.wdata (frm_wdata),
		.raddr (frm_raddr),
		.rdata (frm_rdata)
	);

	// single comparator shared by the stack scan and the frame scan
	assign cmp_a    = (state_q == S_FR_CMP) ? frm_rdata : stk_rdata;
	assign match    = (cmp_a == key_q);
	assign idx_ext  = CW1'(idx_q);
	assign more     = (idx_ext + CW1'(1)) < CW1'(filled_q);
	assign rot_more = (idx_ext + CW1'(2)) < CW1'(filled_q);
	assign full     = (filled_q == CW'(FRAME_COUNT));
	assign top_cnt  = filled_q - CW'(1);
	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (filled_q == '0) ? S_FILL : S_ST_RD;
				end
			end
			S_ST_RD:  state_d = S_ST_CMP;
			S_ST_CMP: begin
				if (match) begin
					state_d = more ? S_ROT_RD : S_TOP_WR;
				end else if (more) begin
					state_d = S_ST_RD;
				end else begin
					state_d = full ? S_EV_RD : S_FILL;
				end
			end
			S_ROT_RD: state_d = S_ROT_WR;
			S_ROT_WR: state_d = rot_more ? S_ROT_RD : S_TOP_WR;
			S_EV_RD:  state_d = S_EV_CAP;
			S_EV_CAP: state_d = S_TOP_WR;
			S_TOP_WR: state_d = S_FR_RD;
			S_FILL:   state_d = S_DONE;
			S_FR_RD:  state_d = S_FR_CMP;
			S_FR_CMP: begin
				if (match || !more) begin
					state_d = S_DONE;
				end else begin
					state_d = S_FR_RD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM controls and handshake outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		stk_we    = 1'b0;
		stk_waddr = idx_q;
		stk_wdata = page_q;
		stk_raddr = idx_q;
		frm_we    = 1'b0;
		frm_waddr = idx_q;
		frm_wdata = page_q;
		frm_raddr = idx_q;
		unique case (state_q)
			S_ROT_RD: stk_raddr = idx_q + IW'(1);
			S_ROT_WR: begin
				stk_we    = 1'b1;
				stk_wdata = stk_rdata;
			end
			S_EV_RD:  stk_raddr = IW'(FRAME_COUNT - 1);
			S_TOP_WR: begin
				stk_we    = 1'b1;
				stk_waddr = top_cnt[IW-1:0];
			end
			S_FILL: begin
				stk_we    = 1'b1;
				stk_waddr = filled_q[IW-1:0];
				frm_we    = 1'b1;
				frm_waddr = filled_q[IW-1:0];
			end
			S_FR_CMP: begin
				// on eviction the new page takes the victim's frame (frame 0 if none found)
				frm_we    = evict_q && (match || !more);
				frm_waddr = match ? idx_q : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			filled_q    <= '0;
			hit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FILL) begin
				filled_q <= filled_q + CW'(1);
			end
			if (state_q == S_ST_CMP && match && hit_cnt_q != '1) begin
				hit_cnt_q <= hit_cnt_q + HIT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q    <= page_id;
			key_q     <= page_id;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			evict_q   <= 1'b0;
			ev_page_q <= '0;
			frame_q   <= '0;
		end
		case (state_q)
			S_ST_CMP: begin
				if (match) begin
					hit_q <= 1'b1;
				end else if (more) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			S_ROT_WR: idx_q <= idx_q + IW'(1);
			S_EV_CAP: begin
				key_q     <= stk_rdata;
				ev_page_q <= stk_rdata;
				evict_q   <= 1'b1;
			end
			S_TOP_WR: idx_q <= '0;
			S_FILL:   frame_q <= filled_q[IW-1:0];
			S_FR_CMP: begin
				if (match) begin
					frame_q <= idx_q;
				end else if (more) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			default: ;
		endcase
		if (load_out) begin
			out_hit_q       <= hit_q;
			out_frame_q     <= frame_q;
			out_evict_q     <= evict_q;
			out_ev_page_q   <= ev_page_q;
			out_hit_total_q <= hit_cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = out_hit_q;
	assign frame_index  = out_frame_q;
	assign evicted      = out_evict_q;
	assign evicted_page = out_ev_page_q;
	assign hit_total    = out_hit_total_q;

endmodule

@@ sv/mrupr_checker.sv @@
// Port-level checks for the MRU page replacement block, plus the bind
// that attaches them. Depends on mrupr_pkg and mru_page_replacement.
module mrupr_checker #(
	parameter int FRAME_COUNT  = 8,
	parameter int PAGE_ID_BITS = 8
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [PAGE_ID_BITS-1:0]        page_id,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           hit,
	input logic [$clog2(FRAME_COUNT)-1:0] frame_index,
	input logic                           evicted,
	input logic [PAGE_ID_BITS-1:0]        evicted_page,
	input logic [mrupr_pkg::HIT_W-1:0]    hit_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit) && $stable(frame_index) && $stable(evicted)
			&& $stable(evicted_page) && $stable(hit_total))
		else $error("stalled result changed");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("hit transaction reports an eviction");

	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> evicted_page == '0)
		else $error("evicted page nonzero without eviction");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("ready again right after accepting a transaction");

endmodule

bind mru_page_replacement mrupr_checker #(
	.FRAME_COUNT  (FRAME_COUNT),
	.PAGE_ID_BITS (PAGE_ID_BITS)
) u_mrupr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.page_id      (page_id),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.hit          (hit),
	.frame_index  (frame_index),
	.evicted      (evicted),
	.evicted_page (evicted_page),
	.hit_total    (hit_total)
);
